// File: sv/m3i_pkg.sv
// Shared types, widths and tables for the 3x3 matrix inverse.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package m3i_pkg;

  localparam int ENTRY_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * ENTRY_WIDTH;          // product of two entries
  localparam int COF_W       = PROD_W + 1;               // cofactor, exact
  localparam int HI_W        = COF_W - ENTRY_WIDTH;      // upper slice of a cofactor
  localparam int PART_W      = ENTRY_WIDTH + HI_W;       // entry times cofactor slice
  localparam int DET_W       = 3 * ENTRY_WIDTH + 3;      // determinant, exact
  localparam int REM_W       = DET_W + 1;                // divider remainder
  localparam int DIV_STEPS   = 2 * FRAC_BITS;            // quotient bits per division
  localparam int NUM_ENTRIES = 9;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

  typedef struct packed {
    entry_t m00; entry_t m01; entry_t m02;
    entry_t m10; entry_t m11; entry_t m12;
    entry_t m20; entry_t m21; entry_t m22;
  } m3i_in_t;

  typedef struct packed {
    entry_t i00; entry_t i01; entry_t i02;
    entry_t i10; entry_t i11; entry_t i12;
    entry_t i20; entry_t i21; entry_t i22;
    logic   singular;
  } m3i_out_t;

  // One matrix after the front end: cofactors, determinant magnitude, sign, zero
  typedef struct packed {
    logic [NUM_ENTRIES-1:0][COF_W-1:0] cof;
    logic [DET_W-1:0]                  det_mag;
    logic                              det_neg;
    logic                              det_zero;
  } m3i_job_t;

  // Inverse entry in row-major order takes the transposed cofactor
  function automatic logic [IDX_W-1:0] adj_src(input logic [IDX_W-1:0] o);
    logic [IDX_W-1:0] s;
    case (o)
      4'd0: s = 4'd0;
      4'd1: s = 4'd3;
      4'd2: s = 4'd6;
      4'd3: s = 4'd1;
      4'd4: s = 4'd4;
      4'd5: s = 4'd7;
      4'd6: s = 4'd2;
      4'd7: s = 4'd5;
      4'd8: s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: sv/m3i_front.sv
// Front end: accepts matrices and forms cofactors and the determinant.
// Six-stage pipeline with one enable; depends on m3i_pkg.
`default_nettype none
module m3i_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3i_pkg::m3i_in_t  in_data,
  output m3i_pkg::m3i_job_t job,
  output logic              job_valid,
  input  logic              job_ready
);
  import m3i_pkg::*;

  logic adv;
  logic v1, v2, v3, v4, v5;
  entry_t a_in [NUM_ENTRIES];
  entry_t b_in [NUM_ENTRIES];
  entry_t c_in [NUM_ENTRIES];
  entry_t d_in [NUM_ENTRIES];
  logic signed [PROD_W-1:0] pa [NUM_ENTRIES];
  logic signed [PROD_W-1:0] pb [NUM_ENTRIES];
  logic signed [COF_W-1:0]  cof2 [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0][COF_W-1:0] cof3, cof4, cof5;
  entry_t row1 [3];
  entry_t row2 [3];
  logic signed [PART_W-1:0] pl [3];
  logic signed [PART_W-1:0] ph [3];
  logic signed [DET_W-1:0]  dj [3];
  logic signed [DET_W-1:0]  det;

  // advance whenever the job register is free or drains
  assign adv      = !job_valid || job_ready;
  assign in_ready = adv;

  // cofactor operands: a*b - c*d, row-major cofactor order
  always_comb begin
    a_in[0] = in_data.m11; b_in[0] = in_data.m22; c_in[0] = in_data.m21; d_in[0] = in_data.m12;
    a_in[1] = in_data.m20; b_in[1] = in_data.m12; c_in[1] = in_data.m10; d_in[1] = in_data.m22;
    a_in[2] = in_data.m10; b_in[2] = in_data.m21; c_in[2] = in_data.m20; d_in[2] = in_data.m11;
    a_in[3] = in_data.m21; b_in[3] = in_data.m02; c_in[3] = in_data.m01; d_in[3] = in_data.m22;
    a_in[4] = in_data.m00; b_in[4] = in_data.m22; c_in[4] = in_data.m20; d_in[4] = in_data.m02;
    a_in[5] = in_data.m20; b_in[5] = in_data.m01; c_in[5] = in_data.m00; d_in[5] = in_data.m21;
    a_in[6] = in_data.m01; b_in[6] = in_data.m12; c_in[6] = in_data.m11; d_in[6] = in_data.m02;
    a_in[7] = in_data.m10; b_in[7] = in_data.m02; c_in[7] = in_data.m00; d_in[7] = in_data.m12;
    a_in[8] = in_data.m00; b_in[8] = in_data.m11; c_in[8] = in_data.m10; d_in[8] = in_data.m01;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      job_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      job_valid <= v5;
    end
  end

  // datapath: products, cofactors, row-0 expansion, sum, magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_ENTRIES; k++) begin
        pa[k]   <= PROD_W'(a_in[k]) * PROD_W'(b_in[k]);
        pb[k]   <= PROD_W'(c_in[k]) * PROD_W'(d_in[k]);
        cof2[k] <= COF_W'(pa[k]) - COF_W'(pb[k]);
        cof3[k] <= cof2[k];
      end
      row1[0] <= in_data.m00; row1[1] <= in_data.m01; row1[2] <= in_data.m02;
      for (int j = 0; j < 3; j++) begin
        row2[j] <= row1[j];
        pl[j] <= PART_W'(row2[j]) *
                 PART_W'($signed({1'b0, cof2[j][ENTRY_WIDTH-1:0]}));
        // upper slice keeps the cofactor's sign
        ph[j] <= PART_W'(row2[j]) *
                 PART_W'($signed(cof2[j][COF_W-1:ENTRY_WIDTH]));
        dj[j] <= (DET_W'(ph[j]) <<< ENTRY_WIDTH) + DET_W'(pl[j]);
      end
      cof4 <= cof3;
      cof5 <= cof4;
      det  <= dj[0] + dj[1] + dj[2];
      job.cof      <= cof5;
      job.det_neg  <= det[DET_W-1];
      job.det_mag  <= det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
      job.det_zero <= (det == '0);
    end
  end

endmodule
`default_nettype wire

// File: sv/m3i_fifo.sv
// Two-entry queue of jobs between the front end and the divider.
// Depends on m3i_pkg.
`default_nettype none
module m3i_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  m3i_pkg::m3i_job_t wr_data,
  input  logic              pop,
  output m3i_pkg::m3i_job_t head,
  output logic              full,
  output logic              empty
);
  import m3i_pkg::*;

  m3i_job_t         mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign head  = mem[rd_ptr];
  assign full  = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign empty = (count == '0);

  // store
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/m3i_back.sv
// Back end: issues one adjugate entry per unstalled cycle into a pipelined restoring
// divider, saturates, gathers nine words and holds the result. Uses m3i_pkg.
`default_nettype none
module m3i_back (
  input  logic              clk,
  input  logic              rst,
  input  m3i_pkg::m3i_job_t head,
  input  logic              job_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output m3i_pkg::m3i_out_t out_data
);
  import m3i_pkg::*;

  localparam int NSTG = DIV_STEPS + 2;
  localparam logic [ENTRY_WIDTH:0] LIM_POS = (ENTRY_WIDTH+1)'((64'd1 << (ENTRY_WIDTH-1)) - 1);
  localparam logic [ENTRY_WIDTH:0] LIM_NEG = (ENTRY_WIDTH+1)'(64'd1 << (ENTRY_WIDTH-1));

  typedef struct packed {
    logic                 valid;
    logic [REM_W-1:0]     r;
    logic [DET_W-1:0]     den;
    logic [DIV_STEPS-1:0] q;
    logic                 neg;
    logic                 big;
    logic                 sing;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } div_t;

  div_t                    st [NSTG];
  div_t                    e;
  logic [IDX_W-1:0]        eidx;
  logic                    adv, stall, issue;
  logic signed [COF_W-1:0] adj;
  logic [COF_W-1:0]        adj_mag;
  logic [ENTRY_WIDTH:0]    qx, lim, mag, val;
  entry_t                  res;
  entry_t                  gather [NUM_ENTRIES];

  assign e     = st[NSTG-1];
  assign stall = e.valid && e.last && out_valid && !out_ready;
  assign adv   = !stall;
  assign issue = job_valid && adv;
  assign pop   = issue && (eidx == LAST_IDX);

  // pick the transposed cofactor for this output word
  assign adj     = $signed(head.cof[adj_src(eidx)]);
  assign adj_mag = adj[COF_W-1] ? COF_W'(-adj) : COF_W'(adj);

  // saturate the quotient and apply the sign; zero for a singular matrix
  always_comb begin
    qx  = (ENTRY_WIDTH+1)'(e.q);
    lim = e.neg ? LIM_NEG : LIM_POS;
    mag = (e.big || qx > lim) ? lim : qx;
    val = e.neg ? -mag : mag;
    res = e.sing ? '0 : entry_t'(val[ENTRY_WIDTH-1:0]);
  end

  // element counter within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      eidx <= '0;
    end else if (issue) begin
      eidx <= (eidx == LAST_IDX) ? '0 : eidx + 1'b1;
    end
  end

  // divider pipeline: issue, range check, then one quotient bit a stage
  always_ff @(posedge clk) begin
    logic [REM_W-1:0] r2;
    logic             ge;
    div_t             nx;
    if (rst) begin
      for (int i = 0; i < NSTG; i++) st[i].valid <= 1'b0;
    end else if (adv) begin
      nx.valid = issue;
      nx.r     = REM_W'(adj_mag);
      nx.den   = head.det_mag;
      nx.q     = '0;
      nx.neg   = adj[COF_W-1] ^ head.det_neg;
      nx.big   = 1'b0;
      nx.sing  = head.det_zero;
      nx.idx   = eidx;
      nx.last  = (eidx == LAST_IDX);
      st[0]   <= nx;
      nx       = st[0];
      nx.big   = (st[0].r >= REM_W'(st[0].den));
      st[1]   <= nx;
      for (int i = 2; i < NSTG; i++) begin
        r2 = {st[i-1].r[REM_W-2:0], 1'b0};
        ge = (r2 >= REM_W'(st[i-1].den));
        nx   = st[i-1];
        nx.r = ge ? r2 - REM_W'(st[i-1].den) : r2;
        nx.q = {st[i-1].q[DIV_STEPS-2:0], ge};
        st[i] <= nx;
      end
    end
  end

  // gather words; load the output register on the last one
  always_ff @(posedge clk) begin
    if (adv && e.valid) begin
      gather[e.idx] <= res;
      if (e.last) begin
        out_data.i00 <= gather[0]; out_data.i01 <= gather[1];
        out_data.i02 <= gather[2]; out_data.i10 <= gather[3];
        out_data.i11 <= gather[4]; out_data.i12 <= gather[5];
        out_data.i20 <= gather[6]; out_data.i21 <= gather[7];
        out_data.i22 <= res;
        out_data.singular <= e.sing;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && e.valid && e.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: sv/matrix3_inverse.sv
// 3x3 matrix inverse by adjugate over determinant, signed Q16.16.
// Matrices overlap: the front end takes new ones while the divider works on
// earlier ones; the shared divider pipeline takes one of the nine quotients
// a cycle unless a held output stalls it.
// Reset (rst, synchronous): empties pipeline, queue and output register.
`default_nettype none
module matrix3_inverse (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  m3i_pkg::m3i_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output m3i_pkg::m3i_out_t out_data
);
  import m3i_pkg::*;

  m3i_job_t job, head;
  logic     job_valid, job_ready, full, empty, pop;

  assign job_ready = !full;

  m3i_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .job, .job_valid, .job_ready
  );

  m3i_fifo u_fifo (
    .clk, .rst,
    .push(job_valid && job_ready), .wr_data(job),
    .pop, .head, .full, .empty
  );

  m3i_back u_back (
    .clk, .rst, .head, .job_valid(!empty), .pop,
    .out_valid, .out_ready, .out_data
  );

`ifndef NO_ASSERTIONS
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.singular |->
      out_data.i00 == 0 && out_data.i01 == 0 && out_data.i02 == 0 &&
      out_data.i10 == 0 && out_data.i11 == 0 && out_data.i12 == 0 &&
      out_data.i20 == 0 && out_data.i21 == 0 && out_data.i22 == 0)
    else $error("singular result with nonzero entries");

  a_reset_clear: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire

// File: tb/m3i_checker.sv
// Checker for the 3x3 matrix inverse: watches both channels, predicts each
// inverse in exact wide arithmetic and compares it. Depends on m3i_pkg.
`timescale 1ns / 1ps
module m3i_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  m3i_pkg::m3i_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  m3i_pkg::m3i_out_t out_data,
  output int                errors,
  output int                pending,
  output int                n_singular,
  output int                n_saturated
);
  import m3i_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam wide_t Q_MAX = wide_t'(32'sh7fffffff);
  localparam wide_t Q_MIN = wide_t'(32'sh80000000);

  m3i_out_t inverse_q[$];

  // Form the inverse exactly: Sarrus determinant, transposed cofactors, divide
  function automatic m3i_out_t invert3(input m3i_in_t m);
    wide_t    a[9];
    wide_t    cof[9];
    wide_t    det;
    wide_t    q;
    entry_t   res[9];
    m3i_out_t r;
    a[0] = m.m00; a[1] = m.m01; a[2] = m.m02;
    a[3] = m.m10; a[4] = m.m11; a[5] = m.m12;
    a[6] = m.m20; a[7] = m.m21; a[8] = m.m22;
    det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
        - a[6]*a[4]*a[2] - a[7]*a[5]*a[0] - a[8]*a[3]*a[1];
    cof[0] = a[4]*a[8] - a[7]*a[5];
    cof[1] = a[6]*a[5] - a[3]*a[8];
    cof[2] = a[3]*a[7] - a[6]*a[4];
    cof[3] = a[7]*a[2] - a[1]*a[8];
    cof[4] = a[0]*a[8] - a[6]*a[2];
    cof[5] = a[6]*a[1] - a[0]*a[7];
    cof[6] = a[1]*a[5] - a[4]*a[2];
    cof[7] = a[3]*a[2] - a[0]*a[5];
    cof[8] = a[0]*a[4] - a[3]*a[1];
    for (int k = 0; k < 9; k++) begin
      if (det == 0) begin
        res[k] = '0;
      end else begin
        // transpose: inverse entry (r,c) takes cofactor (c,r)
        q = (cof[(k % 3) * 3 + k / 3] <<< (2 * FRAC_BITS)) / det;
        if (q > Q_MAX) res[k] = 32'sh7fffffff;
        else if (q < Q_MIN) res[k] = 32'sh80000000;
        else res[k] = entry_t'(q);
      end
    end
    r = '{res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7], res[8],
          det == 0};
    return r;
  endfunction

  initial begin
    errors = 0;
    n_singular = 0;
    n_saturated = 0;
  end

  assign pending = inverse_q.size();

  // Predict on each accepted matrix word
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) inverse_q.push_back(invert3(in_data));
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    m3i_out_t exp_w;
    entry_t   e[9];
    entry_t   g[9];
    if (!rst && out_valid && out_ready) begin
      if (inverse_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, out_data);
      end else begin
        exp_w = inverse_q.pop_front();
        e = '{exp_w.i00, exp_w.i01, exp_w.i02, exp_w.i10, exp_w.i11, exp_w.i12,
              exp_w.i20, exp_w.i21, exp_w.i22};
        g = '{out_data.i00, out_data.i01, out_data.i02, out_data.i10, out_data.i11,
              out_data.i12, out_data.i20, out_data.i21, out_data.i22};
        if (exp_w.singular) n_singular++;
        if (exp_w.singular !== out_data.singular) begin
          errors++;
          $display("%0t: singular expected %b got %b", $time,
                   exp_w.singular, out_data.singular);
        end
        for (int k = 0; k < 9; k++) begin
          if (e[k] == 32'sh7fffffff || e[k] == 32'sh80000000) n_saturated++;
          if (e[k] !== g[k]) begin
            errors++;
            $display("%0t: i%0d%0d expected %h got %h", $time, k / 3, k % 3, e[k], g[k]);
          end
        end
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the 3x3 matrix inverse testbench: clock, reset, stimulus, stalls,
// watchdog and verdict. Depends on m3i_pkg, matrix3_inverse and m3i_checker.
`timescale 1ns / 1ps
module tb_top;
  import m3i_pkg::*;

  localparam int WATCHDOG = 5000;
  localparam int HOLD_CYCLES = 400;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  m3i_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  m3i_out_t out_data;
  logic     in_fire;
  int       errors, pending, n_singular, n_saturated;
  int       idle_pct, stall_pct, quiet;
  bit       hold_req;
  int       n_sent;

  matrix3_inverse dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  m3i_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending),
    .n_singular(n_singular), .n_saturated(n_saturated)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Register input acceptance so the sender reads it at the falling edge
  always @(posedge clk) in_fire <= !rst && in_valid && in_ready;

  // Drive the receiver: random stalls, plus one long hold when asked
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Timeout after %0d idle cycles", quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one matrix word and hold it until accepted, then maybe idle
  task automatic send_matrix(input m3i_in_t m);
    in_valid <= 1;
    in_data <= m;
    do @(negedge clk); while (!in_fire);
    n_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  function automatic entry_t rand_entry();
    case ($urandom_range(9))
      0:       return entry_t'($urandom_range(3) == 0 ? 32'h80000000 : 32'h7fffffff);
      1, 2, 3: return entry_t'($urandom);
      4:       return entry_t'($signed($urandom_range(511)) - 256);
      default: return entry_t'($signed($urandom_range(32'h40000)) - 32'sh20000);
    endcase
  endfunction

  function automatic m3i_in_t rand_matrix();
    m3i_in_t m;
    m = '{rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
          rand_entry(), rand_entry(), rand_entry(), rand_entry()};
    // copy a row now and then so the determinant vanishes
    if ($urandom_range(9) == 0) begin
      m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
    end
    return m;
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_matrix(rand_matrix());
  endtask

  localparam entry_t ONE = 32'sh00010000;
  localparam entry_t MAXV = 32'sh7fffffff;
  localparam entry_t MINV = 32'sh80000000;

  initial begin
    rst = 1;
    in_valid = 0;
    in_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    quiet = 0;
    n_sent = 0;
    repeat (5) @(negedge clk);
    rst <= 0;

    // Directed: identity, zero, tiny and huge diagonals, extremes, singular rows
    send_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    send_matrix('0);
    send_matrix('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    send_matrix('{-ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    send_matrix('{MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV});
    send_matrix('{MINV, 0, 0, 0, MINV, 0, 0, 0, MINV});
    send_matrix('{MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, 1});
    send_matrix('{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV});
    send_matrix('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    send_matrix('{ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 5, 7, 9});
    send_matrix('{2*ONE, ONE, 0, ONE, 2*ONE, ONE, 0, ONE, 2*ONE});
    send_matrix('{0, ONE, 0, 0, 0, ONE, ONE, 0, 0});
    send_matrix('{0, 0, 1, 0, 1, 0, 1, 0, 0});
    send_matrix('{MAXV, MAXV, 0, MINV, MAXV, 0, 0, 0, ONE});
    send_matrix('{-1, 0, 0, 0, -1, 0, 0, 0, MAXV});
    send_matrix('{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE});

    // Random phases with different idle and stall patterns
    random_phase(190, 0, 0);
    random_phase(190, 73, 0);
    random_phase(190, 0, 73);
    random_phase(190, 23, 23);
    // Hold the receiver off while the sender keeps offering words
    hold_req = 1;
    random_phase(190, 0, 0);

    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("Sent %0d matrices: %0d singular, %0d saturated entries, including a long",
             n_sent, n_singular, n_saturated);
    $display("output hold and sender/receiver idle phases");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/m3i_pkg.sv
sv/m3i_front.sv
sv/m3i_fifo.sv
sv/m3i_back.sv
sv/matrix3_inverse.sv
tb/m3i_checker.sv
tb/tb_top.sv
